FILE: rtl/sdes_pkg.sv
// Shared types, register codes and S-box tables for the S-DES CBC byte cipher.
`default_nettype none

package sdes_pkg;

    localparam int unsigned KeyWidth  = 10;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned AddrWidth = 4;
    localparam int unsigned DataWidth = 32;

    typedef enum logic [1:0] {
        REG_SECRET_KEY   = 2'd0,
        REG_INIT_VECTOR  = 2'd1,
        REG_DECRYPT_MODE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [ByteWidth-1:0] k1;
        logic [ByteWidth-1:0] k2;
    } subkeys_t;

    // Tables are indexed by {row, column}, row-major.
    localparam logic [1:0] SBOX0 [16] = '{
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd0,
        2'd0, 2'd2, 2'd1, 2'd3,
        2'd3, 2'd1, 2'd3, 2'd2
    };

    localparam logic [1:0] SBOX1 [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd0,
        2'd2, 2'd1, 2'd0, 2'd3
    };

endpackage

`default_nettype wire

FILE: rtl/sdes_keys.sv
// Subkey schedule: P10, half rotations and P8 give the two round subkeys.
`default_nettype none

module sdes_keys
(
    input  wire logic [sdes_pkg::KeyWidth-1:0] secret_key,
    output sdes_pkg::subkeys_t                 subkeys
);

    logic [9:0] p10;
    logic [4:0] a1;
    logic [4:0] b1;
    logic [4:0] a2;
    logic [4:0] b2;
    logic [9:0] v1;
    logic [9:0] v2;

    function automatic logic [7:0] perm_p8(input logic [9:0] v);
        return {v[4], v[7], v[3], v[6], v[2], v[5], v[0], v[1]};
    endfunction

    always_comb
    begin
        p10 = {secret_key[7], secret_key[5], secret_key[8], secret_key[3], secret_key[6],
               secret_key[0], secret_key[9], secret_key[1], secret_key[2], secret_key[4]};
        a1 = {p10[8:5], p10[9]};
        b1 = {p10[3:0], p10[4]};
        a2 = {a1[2:0], a1[4:3]};
        b2 = {b1[2:0], b1[4:3]};
        v1 = {a1, b1};
        v2 = {a2, b2};
        subkeys.k1 = perm_p8(v1);
        subkeys.k2 = perm_p8(v2);
    end

endmodule

`default_nettype wire

FILE: rtl/sdes_core.sv
// Combinational S-DES cipher with the CBC chain mixing for both directions.
`default_nettype none

module sdes_core
(
    input  wire logic [sdes_pkg::ByteWidth-1:0] data_in,
    input  wire logic [sdes_pkg::ByteWidth-1:0] chain_in,
    input  wire logic                           decrypt,
    input  wire sdes_pkg::subkeys_t             subkeys,
    output logic [sdes_pkg::ByteWidth-1:0]      data_out
);

    logic [7:0] block_in;
    logic [7:0] key_a;
    logic [7:0] key_b;
    logic [7:0] x_ip;
    logic [7:0] x_r1;
    logic [7:0] x_sw;
    logic [7:0] x_r2;
    logic [7:0] x_out;

    function automatic logic [3:0] round_f(input logic [3:0] r, input logic [7:0] k);
        logic [7:0] e;
        logic [1:0] s0;
        logic [1:0] s1;
        e  = {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]} ^ k;
        s0 = sdes_pkg::SBOX0[{e[7], e[4], e[6:5]}];
        s1 = sdes_pkg::SBOX1[{e[3], e[0], e[2:1]}];
        return {s0[0], s1[0], s1[1], s0[1]};
    endfunction

    function automatic logic [7:0] feistel(input logic [7:0] x, input logic [7:0] k);
        return {x[7:4] ^ round_f(x[3:0], k), x[3:0]};
    endfunction

    always_comb
    begin
        block_in = decrypt ? data_in : (data_in ^ chain_in);
        key_a    = decrypt ? subkeys.k2 : subkeys.k1;
        key_b    = decrypt ? subkeys.k1 : subkeys.k2;
        x_ip     = {block_in[6], block_in[2], block_in[5], block_in[7],
                    block_in[4], block_in[0], block_in[3], block_in[1]};
        x_r1     = feistel(x_ip, key_a);
        x_sw     = {x_r1[3:0], x_r1[7:4]};
        x_r2     = feistel(x_sw, key_b);
        x_out    = {x_r2[4], x_r2[7], x_r2[5], x_r2[3], x_r2[1], x_r2[6], x_r2[0], x_r2[2]};
        data_out = decrypt ? (x_out ^ chain_in) : x_out;
    end

endmodule

`default_nettype wire

FILE: rtl/sdes_cbc_byte_cipher.sv
// Top level of the Simplified DES byte cipher in cipher block chaining mode.
//
// Bytes enter on data_byte with in_valid and leave on result_byte with
// out_valid. A word is taken at a clock edge where valid is high and stall
// is low. Every accepted word gives exactly one result word, in order.
// A word is held in the input register, where the cipher and the chain
// update are worked out, and then moves to the output register, which
// shows its result. One word per cycle is sustained while out_stall is
// low; the limit is the single combinational pass of two Feistel rounds
// between the two registers.
// When out_stall holds a result, the output register keeps it and the
// input register still takes a word if it is empty, then raises in_stall.
// Configuration goes through the APB port: the key at 0x0, the initial
// vector at 0x4 (writing it also reloads the chain) and the mode at 0x8.
// Reset clears the valid flags of both pipeline registers and sets key,
// vector, mode and the chain to zero.
`default_nettype none

module sdes_cbc_byte_cipher
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sdes_pkg::AddrWidth-1:0]  paddr,
    input  wire logic [sdes_pkg::DataWidth-1:0]  pwdata,
    output logic      [sdes_pkg::DataWidth-1:0]  prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [sdes_pkg::ByteWidth-1:0]  data_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [sdes_pkg::ByteWidth-1:0]  result_byte
);

    logic [sdes_pkg::KeyWidth-1:0]  key_reg;
    logic [sdes_pkg::ByteWidth-1:0] iv_reg;
    logic                           mode_reg;
    logic [sdes_pkg::ByteWidth-1:0] chain_reg;
    logic [sdes_pkg::ByteWidth-1:0] chain_next;
    logic                           in_valid_reg;
    logic [sdes_pkg::ByteWidth-1:0] in_data_reg;
    logic                           out_valid_reg;
    logic [sdes_pkg::ByteWidth-1:0] result_byte_reg;
    logic [sdes_pkg::ByteWidth-1:0] cipher_out;
    sdes_pkg::subkeys_t             subkeys;
    sdes_pkg::reg_idx_t             reg_idx;
    logic                           cfg_write;
    logic                           in_take;
    logic                           advance;

    assign pready    = 1'b1;
    assign reg_idx   = sdes_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx)
            sdes_pkg::REG_SECRET_KEY:
                prdata = {{(sdes_pkg::DataWidth - sdes_pkg::KeyWidth){1'b0}}, key_reg};
            sdes_pkg::REG_INIT_VECTOR:
                prdata = {{(sdes_pkg::DataWidth - sdes_pkg::ByteWidth){1'b0}}, iv_reg};
            sdes_pkg::REG_DECRYPT_MODE:
                prdata = {{(sdes_pkg::DataWidth - 1){1'b0}}, mode_reg};
            default:
                prdata = '0;
        endcase
    end

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    sdes_keys u_keys
    (
        .secret_key (key_reg),
        .subkeys    (subkeys)
    );

    sdes_core u_core
    (
        .data_in  (in_data_reg),
        .chain_in (chain_reg),
        .decrypt  (mode_reg),
        .subkeys  (subkeys),
        .data_out (cipher_out)
    );

    always_comb
    begin
        chain_next = chain_reg;
        if (cfg_write && (reg_idx == sdes_pkg::REG_INIT_VECTOR))
        begin
            chain_next = pwdata[sdes_pkg::ByteWidth-1:0];
        end
        else if (advance)
        begin
            chain_next = mode_reg ? in_data_reg : cipher_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            iv_reg    <= '0;
            mode_reg  <= 1'b0;
            chain_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
            if (cfg_write)
            begin
                case (reg_idx)
                    sdes_pkg::REG_SECRET_KEY:
                        key_reg <= pwdata[sdes_pkg::KeyWidth-1:0];
                    sdes_pkg::REG_INIT_VECTOR:
                        iv_reg <= pwdata[sdes_pkg::ByteWidth-1:0];
                    sdes_pkg::REG_DECRYPT_MODE:
                        mode_reg <= pwdata[0];
                    default:
                        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= data_byte;
        end
        if (advance)
        begin
            result_byte_reg <= cipher_out;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_byte = result_byte_reg;

endmodule

`default_nettype wire
